>>> sv/status_led_pattern_generator_defines.svh
// Assertion macros for the status LED pattern generator.
`ifndef STATUS_LED_PATTERN_GENERATOR_DEFINES_SVH
`define STATUS_LED_PATTERN_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SLPG_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define SLPG_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/slpg_pkg.sv
// Shared types, constants and sine table function for the status LED pattern generator.
package slpg_pkg;

  localparam int unsigned NOW_W = 32;
  localparam int unsigned PWM_W = 8;
  localparam int unsigned PAT_W = 3;
  localparam int unsigned BRIGHT_W = 8;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned MAG_W = 17;

  localparam int unsigned DEF_PULSE_PERIOD_MS = 2000;
  localparam int unsigned DEF_SINE_QUARTER_ENTRIES = 500;

  localparam int unsigned BLINK_SLOW_MS = 500;
  localparam int unsigned BLINK_FAST_MS = 100;
  localparam int unsigned DBL_PERIOD_MS = 1000;
  localparam int unsigned DBL_ON1_END_MS = 100;
  localparam int unsigned DBL_ON2_START_MS = 200;
  localparam int unsigned DBL_ON2_END_MS = 300;
  localparam int unsigned BRIGHT_RESET = 255;
  localparam int unsigned SINE_ONE = 65536;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [PAT_W-1:0] {
    PAT_OFF    = 3'd0,
    PAT_ON     = 3'd1,
    PAT_SLOW   = 3'd2,
    PAT_FAST   = 3'd3,
    PAT_PULSE  = 3'd4,
    PAT_DOUBLE = 3'd5
  } pattern_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PATTERN    = 2'd0,
    CFG_BRIGHTNESS = 2'd1,
    CFG_ENABLE     = 2'd2
  } cfg_index_t;

  // Restoring shift-subtract quotient, elaboration use only.
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = (rem << 1) | {63'd0, num[b]};
      if (rem >= den) begin
        rem = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter-wave sine entry idx of n, Q1.16, via Q2.30 Taylor series.
  function automatic logic [MAG_W-1:0] sine_entry(input int unsigned idx,
                                                  input int unsigned n);
    longint unsigned x;
    longint unsigned term;
    longint unsigned e;
    longint sum;
    x = udiv64(HALF_PI_Q30 * 64'(idx), 64'(n));
    sum = longint'(x);
    term = x;
    for (int k = 1; k <= 12; k++) begin
      if (term != 0) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = udiv64(term, 64'((2 * k) * (2 * k + 1)));
        if (k[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    e = (longint'(sum) + 64'd8192) >> 14;
    if (e > 64'(SINE_ONE)) begin
      e = 64'(SINE_ONE);
    end
    if (idx == 0) begin
      e = 64'd0;
    end
    if (idx == n) begin
      e = 64'(SINE_ONE);
    end
    return MAG_W'(e);
  endfunction

endpackage

>>> sv/slpg_if.sv
// Update and result channel interfaces of the status LED pattern generator.
interface slpg_in_if;
  logic                        valid;
  logic                        ready;
  logic [slpg_pkg::NOW_W-1:0]  now_ms;

  modport source (output valid, output now_ms, input ready);
  modport sink (input valid, input now_ms, output ready);
endinterface

interface slpg_out_if;
  logic                        valid;
  logic                        ready;
  logic                        led_level;
  logic                        pwm_active;
  logic [slpg_pkg::PWM_W-1:0]  pwm_value;

  modport source (output valid, output led_level, output pwm_active, output pwm_value,
                  input ready);
  modport sink (input valid, input led_level, input pwm_active, input pwm_value,
                output ready);
endinterface

>>> sv/status_led_pattern_generator.sv
// Status LED pattern generator: blink state machine and pipelined sine pulse.
//
//   channel  dir  payload                              handshake
//   update   in   now_ms[31:0]                         valid/ready
//   result   out  led_level, pwm_active, pwm_value[7:0] valid/ready
//   cfg      in   cfg_index[1:0], cfg_wdata[7:0]       cfg_we
//
// One transaction per cycle while the result is not stalled; the result passes through
// the eleven-register pipeline (constant-reciprocal divides, sine ROM read,
// brightness multiply). Blink state updates at the third stage.
// Reset is synchronous: clears pipeline valids and state, pattern off, full brightness.
// A stalled result holds the whole pipeline; update.ready is low then and during reset.
`include "status_led_pattern_generator_defines.svh"

module status_led_pattern_generator #(
  parameter int unsigned PULSE_PERIOD_MS      = slpg_pkg::DEF_PULSE_PERIOD_MS,
  parameter int unsigned SINE_QUARTER_ENTRIES = slpg_pkg::DEF_SINE_QUARTER_ENTRIES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [slpg_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [slpg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  slpg_in_if.sink                           update,
  slpg_out_if.source                        result
);

  localparam int unsigned NSTG   = 11;
  localparam int unsigned PER_L  = $clog2(PULSE_PERIOD_MS);
  localparam int unsigned PER_W  = PER_L + 1;
  localparam int unsigned PER_SH = 31 + PER_L;
  localparam logic [31:0] PER_M  = 32'((64'd1 << PER_SH) / PULSE_PERIOD_MS);
  localparam logic [PER_W-1:0] PER_K = PER_W'(PULSE_PERIOD_MS);
  localparam int unsigned DBL_L  = $clog2(slpg_pkg::DBL_PERIOD_MS);
  localparam int unsigned DBL_W  = DBL_L + 1;
  localparam int unsigned DBL_SH = 31 + DBL_L;
  localparam logic [31:0] DBL_M  = 32'((64'd1 << DBL_SH) / slpg_pkg::DBL_PERIOD_MS);
  localparam logic [DBL_W-1:0] DBL_K = DBL_W'(slpg_pkg::DBL_PERIOD_MS);
  localparam int unsigned NQ4    = 4 * SINE_QUARTER_ENTRIES;
  localparam int unsigned U_W    = $clog2(NQ4);
  localparam int unsigned A_W    = $clog2(SINE_QUARTER_ENTRIES + 1);
  localparam int unsigned MAG_W  = slpg_pkg::MAG_W;
  localparam int unsigned V_W    = MAG_W + 1;
  localparam int unsigned PR_W   = V_W + slpg_pkg::BRIGHT_W;

  typedef logic [MAG_W-1:0] sine_rom_t [SINE_QUARTER_ENTRIES+1];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int unsigned i = 0; i <= SINE_QUARTER_ENTRIES; i++) begin
      rom[i] = slpg_pkg::sine_entry(i, SINE_QUARTER_ENTRIES);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // configuration and state
  logic [slpg_pkg::PAT_W-1:0]    pattern_sel;
  logic [slpg_pkg::BRIGHT_W-1:0] brightness;
  logic                          enable;
  logic                          led_on_flag;
  logic [31:0]                   last_toggle_ms;
  logic                          restart_pending;

  logic                          led_on_flag_next;
  logic [31:0]                   last_toggle_ms_next;

  // pipeline
  logic [NSTG-1:0]               vld;
  logic                          adv;

  logic [31:0]                   s1_now;
  logic [31:0]                   s2_now;
  logic [63:0]                   s2_pp;
  logic [63:0]                   s2_pd;
  logic [31:0]                   s3_now;
  logic [31:0]                   s3_mp;
  logic [31:0]                   s3_md;
  logic [PER_L-1:0]              s4_p;
  logic [31:0]                   s5_t;
  logic [31:0]                   s6_t;
  logic [63:0]                   s6_prod;
  logic [31:0]                   s7_t;
  logic [31:0]                   s7_mu;
  logic [U_W-1:0]                s7_qu;
  logic [U_W-1:0]                s8_u;
  logic [A_W-1:0]                s9_addr;
  logic                          s9_neg;
  logic [MAG_W-1:0]              s10_mag;
  logic                          s10_neg;
  logic [slpg_pkg::PWM_W-1:0]    s11_pwm;

  logic [NSTG-1:3]               led_pipe;
  logic [NSTG-1:3]               pact_pipe;

  // combinational
  logic [PER_W-1:0]              rem_p;
  logic [PER_L-1:0]              phase;
  logic [DBL_W-1:0]              rem_d;
  logic [DBL_L-1:0]              dbl_pos;
  logic [31:0]                   last_base;
  logic [31:0]                   elapsed;
  logic                          led_new;
  logic                          pact_new;
  logic [31:0]                   qu_full;
  logic [PER_W-1:0]              rem_u;
  logic [U_W-1:0]                u_val;
  logic [1:0]                    quad;
  logic [U_W-1:0]                r_val;
  logic [A_W-1:0]                addr;
  logic [V_W-1:0]                v_val;
  logic [PR_W-1:0]               prod;

  assign adv          = !vld[NSTG-1] || result.ready;
  assign update.ready = adv && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], update.valid};
    end
  end

  // phase and double-blink position, then blink state
  always_comb begin
    rem_p   = PER_W'(s3_now - s3_mp);
    phase   = (rem_p >= PER_K) ? PER_L'(rem_p - PER_K) : PER_L'(rem_p);
    rem_d   = DBL_W'(s3_now - s3_md);
    dbl_pos = (rem_d >= DBL_K) ? DBL_L'(rem_d - DBL_K) : DBL_L'(rem_d);

    last_base           = restart_pending ? s3_now : last_toggle_ms;
    elapsed             = s3_now - last_base;
    led_on_flag_next    = led_on_flag;
    last_toggle_ms_next = last_base;
    led_new             = 1'b0;
    pact_new            = 1'b0;
    if (enable) begin
      case (pattern_sel)
        slpg_pkg::PAT_ON: begin
          led_on_flag_next = 1'b1;
        end
        slpg_pkg::PAT_SLOW: begin
          if (elapsed >= slpg_pkg::BLINK_SLOW_MS) begin
            led_on_flag_next    = !led_on_flag;
            last_toggle_ms_next = s3_now;
          end
        end
        slpg_pkg::PAT_FAST: begin
          if (elapsed >= slpg_pkg::BLINK_FAST_MS) begin
            led_on_flag_next    = !led_on_flag;
            last_toggle_ms_next = s3_now;
          end
        end
        slpg_pkg::PAT_PULSE: begin
          pact_new = 1'b1;
        end
        slpg_pkg::PAT_DOUBLE: begin
          led_on_flag_next = dbl_pos inside {[0 : slpg_pkg::DBL_ON1_END_MS - 1],
              [slpg_pkg::DBL_ON2_START_MS : slpg_pkg::DBL_ON2_END_MS - 1]};
        end
        default: begin
          led_on_flag_next = 1'b0;
        end
      endcase
      led_new = (pattern_sel != slpg_pkg::PAT_PULSE) && led_on_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_sel     <= slpg_pkg::PAT_OFF;
      brightness      <= slpg_pkg::BRIGHT_W'(slpg_pkg::BRIGHT_RESET);
      enable          <= 1'b1;
      led_on_flag     <= 1'b0;
      last_toggle_ms  <= '0;
      restart_pending <= 1'b1;
    end else begin
      if (adv && vld[2]) begin
        led_on_flag     <= led_on_flag_next;
        last_toggle_ms  <= last_toggle_ms_next;
        restart_pending <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          slpg_pkg::CFG_PATTERN: begin
            pattern_sel     <= cfg_wdata[slpg_pkg::PAT_W-1:0];
            restart_pending <= 1'b1;
          end
          slpg_pkg::CFG_BRIGHTNESS: begin
            brightness <= cfg_wdata[slpg_pkg::BRIGHT_W-1:0];
          end
          slpg_pkg::CFG_ENABLE: begin
            enable <= cfg_wdata[0];
            if (!cfg_wdata[0]) begin
              led_on_flag <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // sine index: quotient correction and quadrant split, then sine level and brightness product
  always_comb begin
    qu_full = 32'(s6_prod >> PER_SH);
    rem_u   = PER_W'(s7_t - s7_mu);
    u_val   = (rem_u >= PER_K) ? U_W'(s7_qu + 1'b1) : s7_qu;
    if (s8_u >= U_W'(3 * SINE_QUARTER_ENTRIES)) begin
      quad  = 2'd3;
      r_val = U_W'(s8_u - U_W'(3 * SINE_QUARTER_ENTRIES));
    end else if (s8_u >= U_W'(2 * SINE_QUARTER_ENTRIES)) begin
      quad  = 2'd2;
      r_val = U_W'(s8_u - U_W'(2 * SINE_QUARTER_ENTRIES));
    end else if (s8_u >= U_W'(SINE_QUARTER_ENTRIES)) begin
      quad  = 2'd1;
      r_val = U_W'(s8_u - U_W'(SINE_QUARTER_ENTRIES));
    end else begin
      quad  = 2'd0;
      r_val = s8_u;
    end
    addr  = quad[0] ? A_W'(SINE_QUARTER_ENTRIES - 32'(r_val)) : A_W'(r_val);
    v_val = s10_neg ? V_W'(V_W'(slpg_pkg::SINE_ONE) - V_W'(s10_mag))
                    : V_W'(V_W'(slpg_pkg::SINE_ONE) + V_W'(s10_mag));
    prod  = PR_W'(v_val) * PR_W'(brightness);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_now    <= update.now_ms;
      s2_now    <= s1_now;
      s2_pp     <= 64'(s1_now) * 64'(PER_M);
      s2_pd     <= 64'(s1_now) * 64'(DBL_M);
      s3_now    <= s2_now;
      s3_mp     <= 32'(32'(s2_pp >> PER_SH) * 32'(PER_K));
      s3_md     <= 32'(32'(s2_pd >> DBL_SH) * 32'(DBL_K));
      s4_p      <= phase;
      s5_t      <= 32'(s4_p) * 32'(NQ4);
      s6_t      <= s5_t;
      s6_prod   <= 64'(s5_t) * 64'(PER_M);
      s7_t      <= s6_t;
      s7_mu     <= qu_full * 32'(PER_K);
      s7_qu     <= U_W'(qu_full);
      s8_u      <= u_val;
      s9_addr   <= addr;
      s9_neg    <= quad[1];
      s10_mag   <= SINE_ROM[s9_addr];
      s10_neg   <= s9_neg;
      s11_pwm   <= pact_pipe[9] ? prod[PR_W-2:PR_W-1-slpg_pkg::PWM_W] : '0;
      led_pipe  <= {led_pipe[NSTG-2:3], led_new};
      pact_pipe <= {pact_pipe[NSTG-2:3], pact_new};
    end
  end

  assign result.valid      = vld[NSTG-1];
  assign result.led_level  = led_pipe[NSTG-1];
  assign result.pwm_active = pact_pipe[NSTG-1];
  assign result.pwm_value  = s11_pwm;

  `SLPG_ASSERT_IMP(a_pwm_gated, result.valid && !result.pwm_active, result.pwm_value == 8'd0, "pwm value without pulse")
  `SLPG_ASSERT_IMP(a_led_pwm_excl, result.valid, !(result.led_level && result.pwm_active), "led and pwm both driven")
  `SLPG_ASSERT_NXT(a_disable_clears, cfg_we && cfg_index == slpg_pkg::CFG_ENABLE && !cfg_wdata[0], !led_on_flag, "led flag kept after disable")
  `SLPG_ASSERT_NXT(a_restart_armed, cfg_we && cfg_index == slpg_pkg::CFG_PATTERN, restart_pending, "restart not armed")
  `SLPG_ASSERT_NXT(a_stall_holds, !adv, $stable(vld), "pipeline moved during stall")

endmodule
